// ===== sv/b32id_pkg.sv =====
// Shared types and constants for the base-32 identifier string decoder.
`timescale 1ns / 1ps

package b32id_pkg;

   // Number of base-32 digits in one identifier (13 x 5 bits covers 64 bits).
   localparam int unsigned DigitsPerId = 13;
   localparam int unsigned CountWidth  = 4;
   localparam int unsigned ValueWidth  = 64;
   localparam int unsigned DigitWidth  = 5;

   localparam logic [CountWidth-1:0] FullCount = CountWidth'(DigitsPerId);

   // Character codes that the classifier recognizes.
   localparam logic [7:0] ChUpperA   = 8'h41;
   localparam logic [7:0] ChUpperZ   = 8'h5A;
   localparam logic [7:0] ChLowerA   = 8'h61;
   localparam logic [7:0] ChLowerZ   = 8'h7A;
   localparam logic [7:0] ChTwo      = 8'h32;
   localparam logic [7:0] ChSeven    = 8'h37;
   localparam logic [7:0] ChZero     = 8'h30;
   localparam logic [7:0] ChOne      = 8'h31;
   localparam logic [7:0] ChHyphen   = 8'h2D;
   localparam logic [7:0] TwoBias    = 8'h18;   // '2' - 26
   localparam logic [DigitWidth-1:0] DigitOhLetter = 5'd14;  // 'O' - 'A'
   localparam logic [DigitWidth-1:0] DigitIeLetter = 5'd8;   // 'I' - 'A'

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_CHAR  = 3'd1,
      STATUS_BAD_START = 3'd2,
      STATUS_TOO_LONG  = 3'd3,
      STATUS_TOO_SHORT = 3'd4
   } status_type;

   // What one character means to the decoder.
   typedef struct packed {
      logic                  is_digit;
      logic                  is_sep;
      logic [DigitWidth-1:0] digit;
   } char_class_type;

endpackage

// ===== sv/b32id_classify.sv =====
// Character classifier: maps one ASCII byte to a base-32 digit, separator or bad code.
`timescale 1ns / 1ps

module b32id_classify (
   input  logic [7:0]                 char_code,
   output b32id_pkg::char_class_type  char_class
);

   logic [7:0] upper_off;
   logic [7:0] lower_off;
   logic [7:0] num_off;

   assign upper_off = char_code - b32id_pkg::ChUpperA;
   assign lower_off = char_code - b32id_pkg::ChLowerA;
   assign num_off   = char_code - b32id_pkg::TwoBias;

   always_comb begin
      char_class.is_digit = 1'b0;
      char_class.is_sep   = 1'b0;
      char_class.digit    = '0;
      priority if (char_code >= b32id_pkg::ChUpperA && char_code <= b32id_pkg::ChUpperZ) begin
         char_class.is_digit = 1'b1;
         char_class.digit    = upper_off[b32id_pkg::DigitWidth-1:0];
      end else if (char_code >= b32id_pkg::ChTwo && char_code <= b32id_pkg::ChSeven) begin
         char_class.is_digit = 1'b1;
         char_class.digit    = num_off[b32id_pkg::DigitWidth-1:0];
      end else if (char_code == b32id_pkg::ChHyphen) begin
         char_class.is_sep   = 1'b1;
      end else if (char_code >= b32id_pkg::ChLowerA && char_code <= b32id_pkg::ChLowerZ) begin
         char_class.is_digit = 1'b1;
         char_class.digit    = lower_off[b32id_pkg::DigitWidth-1:0];
      end else if (char_code == b32id_pkg::ChZero) begin
         char_class.is_digit = 1'b1;
         char_class.digit    = b32id_pkg::DigitOhLetter;
      end else if (char_code == b32id_pkg::ChOne) begin
         char_class.is_digit = 1'b1;
         char_class.digit    = b32id_pkg::DigitIeLetter;
      end else begin
         // Neither digit nor separator: a bad character.
      end
   end

endmodule

// ===== sv/base32_id_string_decoder.sv =====
// Top level of the base-32 identifier string decoder.
`timescale 1ns / 1ps

//  Channel   Direction  Ports                                    Beat
//  req       in         req_valid, req_stall, req_char_code,     one character
//                       req_last_char
//  rsp       out        rsp_valid, rsp_stall, rsp_decoded_value, one decoded identifier
//                       rsp_status
//
//  One character is taken per cycle while req_stall is low. A character waits in the input
//  register, where its classification, shift-or accumulate and error check form
//  the next decoder state. The character marked last also loads the result
//  register as it leaves the input register, so rsp_valid rises once the result register holds it.
//  Reset clears the input and result valids, the accumulator, digit count and
//  latched error. req_stall rises only when a last character waits in the input
//  register while an earlier result is still held by rsp_stall.

module base32_id_string_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_decoded_value,
   output logic [2:0]  rsp_status
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;
   logic       in_last_ff, in_last_in;

   // Decoder state carried from character to character.
   logic [b32id_pkg::ValueWidth-1:0] acc_ff, acc_in;
   logic [b32id_pkg::CountWidth-1:0] count_ff, count_in;
   b32id_pkg::status_type            err_ff, err_in;

   // Result register.
   logic                             out_valid_ff, out_valid_in;
   logic [b32id_pkg::ValueWidth-1:0] out_value_ff, out_value_in;
   b32id_pkg::status_type            out_status_ff, out_status_in;

   b32id_pkg::char_class_type        char_class;
   logic                             advance;
   logic                             rsp_free;
   logic                             req_take;
   logic [b32id_pkg::ValueWidth-1:0] acc_next;
   logic [b32id_pkg::CountWidth-1:0] count_next;
   b32id_pkg::status_type            err_next;
   b32id_pkg::status_type            final_status;

   b32id_classify u_classify (
      .char_code  (in_char_ff),
      .char_class (char_class)
   );

   // The result register can take a new beat if it is empty or being drained.
   assign rsp_free  = !out_valid_ff || !rsp_stall;
   // A character leaves the input register unless it must load a busy result register.
   assign advance   = in_valid_ff && (!in_last_ff || rsp_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Per-character update. Once an error is latched, characters are ignored.
   always_comb begin
      acc_next   = acc_ff;
      count_next = count_ff;
      err_next   = err_ff;
      if (err_ff == b32id_pkg::STATUS_OK) begin
         if (!char_class.is_digit && !char_class.is_sep) begin
            err_next = b32id_pkg::STATUS_BAD_CHAR;
         end else if (char_class.is_digit) begin
            acc_next   = {acc_ff[b32id_pkg::ValueWidth-b32id_pkg::DigitWidth-1:0],
                          char_class.digit};
            count_next = count_ff + 1'b1;
            if (count_next == b32id_pkg::CountWidth'(1)) begin
               // The leading digit must fit in four bits so 13 digits fit in 64.
               if (char_class.digit[b32id_pkg::DigitWidth-1]) begin
                  err_next = b32id_pkg::STATUS_BAD_START;
               end
            end else if (count_next > b32id_pkg::FullCount) begin
               err_next = b32id_pkg::STATUS_TOO_LONG;
            end
         end
      end
   end

   always_comb begin
      final_status = err_next;
      if (err_next == b32id_pkg::STATUS_OK && count_next != b32id_pkg::FullCount) begin
         final_status = b32id_pkg::STATUS_TOO_SHORT;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_char_in  = req_char_code;
         in_last_in  = req_last_char;
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      count_in = count_ff;
      err_in   = err_ff;
      if (advance) begin
         if (in_last_ff) begin
            // A delivered string leaves the decoder clean for the next one.
            acc_in   = '0;
            count_in = '0;
            err_in   = b32id_pkg::STATUS_OK;
         end else begin
            acc_in   = acc_next;
            count_in = count_next;
            err_in   = err_next;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      if (advance && in_last_ff) begin
         out_valid_in  = 1'b1;
         out_status_in = final_status;
         out_value_in  = (final_status == b32id_pkg::STATUS_OK) ? acc_next : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         count_ff     <= '0;
         err_ff       <= b32id_pkg::STATUS_OK;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff    <= in_char_in;
      in_last_ff    <= in_last_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_decoded_value = out_value_ff;
   assign rsp_status        = out_status_ff;

   // The digit count stops at fourteen because the too-long error freezes it.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= b32id_pkg::CountWidth'(b32id_pkg::DigitsPerId + 1))
      else $error("digit count ran past fourteen");

   // A failed decode never exposes a partial value.
   a_value_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != b32id_pkg::STATUS_OK |-> rsp_decoded_value == '0)
      else $error("nonzero value with error status");

   // Delivering a result clears the decoder state.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> count_ff == '0 && acc_ff == '0
                                && err_ff == b32id_pkg::STATUS_OK)
      else $error("state not cleared after last character");

   // The input side stalls only behind a held result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_last_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a held result");

   // A held result is not overwritten.
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_decoded_value)
                                 && $stable(rsp_status))
      else $error("held result changed");

endmodule
